>>> hdl/lsh_pkg.sv
// Shared constants, types and the sharpening kernel for the Laplacian sharpener.
// No dependencies; imported by the stream interfaces and the core.
`default_nettype none

package lsh_pkg;

  // Frame limits and field widths
  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 10;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = DIM_W;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(400);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // Up to three results per pixel
  localparam int unsigned RES_CNT_W = 2;

  // Pixel held in the input stage with its position flags
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             row_top;
    logic             row_last;
    logic             col_first;
    logic             col_ge2;
    logic             col_last;
  } s0_t;

  // One result beat
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             frame_done;
  } result_t;

  // Register value 0 acts as 1, values above the limit act as the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] val,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] res;
    res = val;
    if (val == '0) begin
      res = DIM_W'(1);
    end else if (val > lim) begin
      res = lim;
    end
    return res;
  endfunction

  // 5*centre minus the four neighbors, clamped to 0..255
  function automatic logic [PIX_W-1:0] sharpen(input logic [PIX_W-1:0] cen,
                                               input logic [PIX_W-1:0] up,
                                               input logic [PIX_W-1:0] dn,
                                               input logic [PIX_W-1:0] lf,
                                               input logic [PIX_W-1:0] rt);
    logic [10:0]        five;
    logic [9:0]         sum4;
    logic signed [11:0] v;
    logic [PIX_W-1:0]   res;
    five = {1'b0, cen, 2'b00} + 11'(cen);
    sum4 = 10'(up) + 10'(dn) + 10'(lf) + 10'(rt);
    v    = $signed({1'b0, five}) - $signed({2'b00, sum4});
    if (v < 12'sd0) begin
      res = '0;
    end else if (v > 12'sd255) begin
      res = '1;
    end else begin
      res = v[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/lsh_in_if.sv
// Input pixel stream: valid/ready handshake carrying one grey pixel per beat.
// Depends on lsh_pkg.
`default_nettype none

interface lsh_in_if;
  import lsh_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

>>> hdl/lsh_out_if.sv
// Output result stream: valid/ready handshake carrying one sharpened pixel
// with its position and markers per beat. Depends on lsh_pkg.
`default_nettype none

interface lsh_out_if;
  import lsh_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             run_last;
  logic             frame_done;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output run_last, output frame_done, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input run_last, input frame_done, output ready);
endinterface

`default_nettype wire

>>> hdl/laplacian_sharpen_3x3_core.sv
// Streaming 4-neighbor Laplacian sharpener with two line buffers.
// Depends on lsh_pkg, lsh_in_if and lsh_out_if.
`default_nettype none

// Pixels enter in raster order, one per clock when the output side keeps up.
// Result (r,c) leaves when pixel (r+1,c) has come in; the bottom row is
// finished while it streams in, so a bottom-row pixel past the first column
// yields two results and the final pixel of the frame three. The output port
// moves one result per beat, so the sustained rate is one pixel per cycle in
// every row but the last; in the last row the single result port holds back
// the input while each pixel's extra results leave. The first result of a
// pixel passes through the input stage, with registered line-buffer reads,
// and then the result buffer. The user must write image width and height
// through the config port only while the stream is idle; the block does not
// enforce this. Line buffers are not cleared after reset and need no clearing
// pass: every entry is written before its value is used in a normal frame.
module laplacian_sharpen_3x3_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lsh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lsh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lsh_in_if.sink                            pix_i,
  lsh_out_if.source                         pix_o
);
  import lsh_pkg::*;

  // ---------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0] cfg_width_q, cfg_height_q;
  logic [DIM_W-1:0] eff_w, eff_h;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] col_ext, row_ext, col_cur, row_step, row_cur;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             wrap_col;
  logic [COL_W-1:0] rd_addr, rd_addr_nxt;

  logic             in_fire, out_fire, load;
  logic             s0_valid_q;
  s0_t              s0_q, s0_d;

  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] upp_mem [MAX_WIDTH];
  logic [PIX_W-1:0] mid_c_q, mid_r_q, upp_c_q;
  logic [PIX_W-1:0] upp_wdata;

  logic [PIX_W-1:0] m_prev_q, prev1_q, prev2_q;

  logic [PIX_W-1:0] left_a, right_a, left_b, up_b, left_c, up_c;
  result_t          res_a, res_b, res_c;
  logic             has_a, has_b, has_c;
  logic [RES_CNT_W-1:0] n_new, rem_q;
  result_t          slot_q [3];
  result_t          slot_d [3];

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= DIM_RESET;
      cfg_height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_w = eff_dim(cfg_width_q, DIM_W'(MAX_WIDTH));
  assign eff_h = eff_dim(cfg_height_q, DIM_W'(MAX_HEIGHT));

  // ---------------------------------------------------------------------
  // Raster position of the incoming pixel (counters may sit beyond a
  // shrunken frame and wrap first)
  // ---------------------------------------------------------------------
  always_comb begin
    col_ext  = DIM_W'(col_q);
    row_ext  = DIM_W'(row_q);
    wrap_col = (col_ext >= eff_w);
    col_cur  = wrap_col ? '0 : col_ext;
    row_step = wrap_col ? row_ext + DIM_W'(1) : row_ext;
    row_cur  = (row_step >= eff_h) ? '0 : row_step;

    col_inc = col_cur + DIM_W'(1);
    row_inc = row_cur + DIM_W'(1);
    if (col_inc >= eff_w) begin
      col_d = '0;
      row_d = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = row_cur[ROW_W-1:0];
    end

    rd_addr     = col_cur[COL_W-1:0];
    rd_addr_nxt = col_inc[COL_W-1:0];

    s0_d.pix       = pix_i.pixel_in;
    s0_d.row       = row_cur[ROW_W-1:0];
    s0_d.col       = col_cur[COL_W-1:0];
    s0_d.row_top   = (row_cur == '0);
    s0_d.row_last  = (row_inc == eff_h);
    s0_d.col_first = (col_cur == '0);
    s0_d.col_ge2   = (col_cur >= DIM_W'(2));
    s0_d.col_last  = (col_inc == eff_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  assign out_fire    = pix_o.valid && pix_o.ready;
  assign load        = s0_valid_q &&
                       ((rem_q == '0) || ((rem_q == RES_CNT_W'(1)) && out_fire));
  assign pix_i.ready = !s0_valid_q || load;
  assign in_fire     = pix_i.valid && pix_i.ready;

  // ---------------------------------------------------------------------
  // Input stage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_fire) begin
      s0_valid_q <= 1'b1;
    end else if (load) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_q <= s0_d;
    end
  end

  // Middle line: row above the incoming pixel; read at c and c+1 before the
  // new pixel overwrites entry c
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mid_mem[rd_addr] <= pix_i.pixel_in;
      mid_c_q          <= mid_mem[rd_addr];
      mid_r_q          <= mid_mem[rd_addr_nxt];
    end
  end

  // Upper line: written as the staged pixel moves on, with bypass when the
  // next beat reads the same column (one-column frames)
  assign upp_wdata = s0_q.row_top ? s0_q.pix : mid_c_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      upp_mem[s0_q.col] <= upp_wdata;
    end
    if (in_fire) begin
      if (load && (s0_q.col == rd_addr)) begin
        upp_c_q <= upp_wdata;
      end else begin
        upp_c_q <= upp_mem[rd_addr];
      end
    end
  end

  // Previous beat's values: left neighbor of the row above, last two pixels
  always_ff @(posedge clk_i) begin
    if (load) begin
      m_prev_q <= mid_c_q;
      prev1_q  <= s0_q.pix;
      prev2_q  <= prev1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stencil: row above at column c, bottom row at c-1, bottom-right corner
  // ---------------------------------------------------------------------
  always_comb begin
    left_a  = s0_q.col_first ? mid_c_q : m_prev_q;
    right_a = s0_q.col_last  ? mid_c_q : mid_r_q;
    res_a.pixel      = sharpen(mid_c_q, upp_c_q, s0_q.pix, left_a, right_a);
    res_a.row        = POS_W'(s0_q.row - ROW_W'(1));
    res_a.col        = POS_W'(s0_q.col);
    res_a.frame_done = 1'b0;

    left_b = s0_q.col_ge2 ? prev2_q : prev1_q;
    up_b   = s0_q.row_top ? prev1_q : m_prev_q;
    res_b.pixel      = sharpen(prev1_q, up_b, prev1_q, left_b, s0_q.pix);
    res_b.row        = POS_W'(s0_q.row);
    res_b.col        = POS_W'(s0_q.col - COL_W'(1));
    res_b.frame_done = 1'b0;

    left_c = s0_q.col_first ? s0_q.pix : prev1_q;
    up_c   = s0_q.row_top ? s0_q.pix : mid_c_q;
    res_c.pixel      = sharpen(s0_q.pix, up_c, s0_q.pix, left_c, s0_q.pix);
    res_c.row        = POS_W'(s0_q.row);
    res_c.col        = POS_W'(s0_q.col);
    res_c.frame_done = 1'b1;

    has_a = !s0_q.row_top;
    has_b = s0_q.row_last && !s0_q.col_first;
    has_c = s0_q.row_last && s0_q.col_last;
    n_new = RES_CNT_W'(has_a) + RES_CNT_W'(has_b) + RES_CNT_W'(has_c);
  end

  // ---------------------------------------------------------------------
  // Result buffer: packs the beat's results in order, shifts one per beat
  // ---------------------------------------------------------------------
  always_comb begin
    slot_d[0] = has_a ? res_a : (has_b ? res_b : res_c);
    slot_d[1] = (has_a && has_b) ? res_b : res_c;
    slot_d[2] = res_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load) begin
      rem_q <= n_new;
    end else if (out_fire) begin
      rem_q <= rem_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot_q[0] <= slot_d[0];
      slot_q[1] <= slot_d[1];
      slot_q[2] <= slot_d[2];
    end else if (out_fire) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

  assign pix_o.valid      = (rem_q != '0);
  assign pix_o.pixel_out  = slot_q[0].pixel;
  assign pix_o.out_row    = slot_q[0].row;
  assign pix_o.out_col    = slot_q[0].col;
  assign pix_o.frame_done = slot_q[0].frame_done;
  assign pix_o.run_last   = (rem_q == RES_CNT_W'(1));

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // The frame's corner pixel is always the last result of its beat
  a_corner_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.frame_done) |-> (rem_q == RES_CNT_W'(1)))
    else $error("frame_done on a result that is not the beat's last");

  // Counters stay inside the frame after each beat
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i) |=> (DIM_W'(col_q) < eff_w))
    else $error("column counter outside frame width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i) |=> (DIM_W'(row_q) < eff_h))
    else $error("row counter outside frame height");

  // Staged pixel waits while more than one result is still queued
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && (rem_q > RES_CNT_W'(1))) |=> s0_valid_q)
    else $error("staged pixel dropped while results pending");

endmodule

`default_nettype wire
